@@ rtl/frdm_pkg.sv @@
// Shared operation and status codes for the frame ring dedup manager.
`timescale 1ns / 1ps

package frdm_pkg;

    typedef enum logic [1:0] {
        OP_ARRIVAL = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_STORED       = 3'd0,
        ST_DROPPED      = 3'd1,
        ST_HANDED_OUT   = 3'd2,
        ST_BUSY         = 3'd3,
        ST_EMPTY        = 3'd4,
        ST_RELEASED     = 3'd5,
        ST_REL_IGNORED  = 3'd6,
        ST_CLEARED      = 3'd7
    } t_status;

    localparam int unsigned FP_W   = 128;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned IDX_W  = 32;
    localparam int unsigned IN_W   = 232;
    localparam int unsigned OUT_W  = 232;
    localparam int unsigned ENTRY_W = ID_W + 2 * TIME_W;

endpackage

@@ rtl/frame_ring_dedup_manager.sv @@
// Top level of the frame ring dedup manager: slot bookkeeping and slot memory.
`timescale 1ns / 1ps

// Channel      | Direction | Handshake                      | Payload
// -------------+-----------+--------------------------------+------------------------------
// s_axis       | in        | s_axis_tvalid / s_axis_tready  | tdata: request fields, tuser: op
// m_axis       | out       | m_axis_tvalid / m_axis_tready  | tdata: result fields, tuser: status
//
// Every request gives exactly one result. For arrival, release, clear and a refused
// acquire the result is registered in the cycle after acceptance; a successful acquire
// first reads the slot memory in state S_READ, then registers the result. One request is
// in flight at a time; the next is taken in the cycle the result register empties,
// so a stalled consumer stalls the input. Reset (i_rst_n low, synchronous) empties
// the ring and clears all counters; the slot memory is not cleared, a slot is read only once written.

module frame_ring_dedup_manager #(
    parameter int unsigned RING_SLOTS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, low bit up: fingerprint_valid(1), fingerprint_w0..w3(32 each),
    // content_time(48), arrival_time(48), release_slot(3), zero pad(4)
    input  logic [frdm_pkg::IN_W-1:0]  s_axis_tdata,
    // tuser: operation(2)
    input  logic [1:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata, low bit up: slot(3), frame_id(32), frame_content_time(48),
    // frame_arrival_time(48), queue_depth(3), pending_was_duplicate(1),
    // oldest_dropped(1), overflow_count(32), duplicate_count(32),
    // timestamp_repeat_count(32)
    output logic [frdm_pkg::OUT_W-1:0] m_axis_tdata,
    // tuser: status(3)
    output logic [2:0]                 m_axis_tuser
);

    import frdm_pkg::*;

    localparam int unsigned SLOT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int unsigned DEPTH_W = $clog2(RING_SLOTS + 1);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Advance a slot pointer alongside its 32-bit index; the index wrap restarts
    // the slot at zero, which keeps slot == index mod RING_SLOTS for any depth.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                   input logic [IDX_W-1:0]  idx);
        logic [SLOT_W-1:0] r;
        if (idx == {IDX_W{1'b1}}) begin
            r = '0;
        end else if (s == SLOT_W'(RING_SLOTS - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    // Unpack request fields.
    t_op                 in_op;
    logic                in_fp_valid;
    logic [FP_W-1:0]     in_fp;
    logic [TIME_W-1:0]   in_ctime;
    logic [TIME_W-1:0]   in_atime;
    logic [2:0]          in_rel_slot;

    assign in_op       = t_op'(s_axis_tuser);
    assign in_fp_valid = s_axis_tdata[0];
    assign in_fp       = s_axis_tdata[128:1];
    assign in_ctime    = s_axis_tdata[176:129];
    assign in_atime    = s_axis_tdata[224:177];
    assign in_rel_slot = s_axis_tdata[227:225];

    // Control and bookkeeping registers.
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_head_idx, n_head_idx;
    logic [IDX_W-1:0]    r_tail_idx, n_tail_idx;
    logic [SLOT_W-1:0]   r_head_slot, n_head_slot;
    logic [SLOT_W-1:0]   r_tail_slot, n_tail_slot;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic                r_held_valid, n_held_valid;
    logic [SLOT_W-1:0]   r_held_slot, n_held_slot;
    logic                r_pending_valid, n_pending_valid;
    logic [FP_W-1:0]     r_last_fp, n_last_fp;
    logic                r_last_fp_valid, n_last_fp_valid;
    logic [TIME_W-1:0]   r_last_ctime, n_last_ctime;
    logic                r_last_time_valid, n_last_time_valid;
    logic [ID_W-1:0]     r_next_id, n_next_id;
    logic [CNT_W-1:0]    r_overflows, n_overflows;
    logic [CNT_W-1:0]    r_duplicates, n_duplicates;
    logic [CNT_W-1:0]    r_time_repeats, n_time_repeats;

    // Result register.
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [2:0]          r_out_slot, n_out_slot;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [TIME_W-1:0]   r_out_ctime, n_out_ctime;
    logic [TIME_W-1:0]   r_out_atime, n_out_atime;
    logic [2:0]          r_out_depth, n_out_depth;
    logic                r_out_dup, n_out_dup;
    logic                r_out_dropped, n_out_dropped;

    // Slot memory: frame id, content time, arrival time per slot.
    logic [ENTRY_W-1:0]  r_mem [RING_SLOTS];
    logic [ENTRY_W-1:0]  r_rd_data;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [SLOT_W-1:0]   mem_raddr;

    // Arrival helpers.
    logic                accept;
    logic                fp_match;
    logic                is_dup;
    logic                settle_adv;
    logic [IDX_W-1:0]    head_idx_s;
    logic [SLOT_W-1:0]   head_slot_s;
    logic [DEPTH_W-1:0]  depth_s;
    logic                ring_full;
    logic                oldest_held;
    logic [31:0]         slot_wide;
    logic [31:0]         depth_wide;

    // Take a request only between items, when the result register frees up.
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Settle the pending frame against the last published fingerprint.
    assign fp_match    = (in_fp == r_last_fp);
    assign is_dup      = r_pending_valid && in_fp_valid && r_last_fp_valid && fp_match;
    assign settle_adv  = r_pending_valid && !is_dup;
    assign head_idx_s  = settle_adv ? (r_head_idx + IDX_W'(1)) : r_head_idx;
    assign head_slot_s = settle_adv ? slot_inc(r_head_slot, r_head_idx) : r_head_slot;
    assign depth_s     = settle_adv ? (r_depth + DEPTH_W'(1)) : r_depth;
    assign ring_full   = (depth_s >= DEPTH_W'(RING_SLOTS - 1));
    assign oldest_held = r_held_valid && (r_tail_slot == r_held_slot);

    always_comb begin
        n_state           = r_state;
        n_head_idx        = r_head_idx;
        n_tail_idx        = r_tail_idx;
        n_head_slot       = r_head_slot;
        n_tail_slot       = r_tail_slot;
        n_depth           = r_depth;
        n_held_valid      = r_held_valid;
        n_held_slot       = r_held_slot;
        n_pending_valid   = r_pending_valid;
        n_last_fp         = r_last_fp;
        n_last_fp_valid   = r_last_fp_valid;
        n_last_ctime      = r_last_ctime;
        n_last_time_valid = r_last_time_valid;
        n_next_id         = r_next_id;
        n_overflows       = r_overflows;
        n_duplicates      = r_duplicates;
        n_time_repeats    = r_time_repeats;

        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_id      = r_out_id;
        n_out_ctime   = r_out_ctime;
        n_out_atime   = r_out_atime;
        n_out_depth   = r_out_depth;
        n_out_dup     = r_out_dup;
        n_out_dropped = r_out_dropped;

        mem_we    = 1'b0;
        mem_waddr = head_slot_s;
        mem_wdata = {in_atime, in_ctime, r_next_id};
        mem_re    = 1'b0;
        mem_raddr = r_tail_slot;

        slot_wide  = '0;
        depth_wide = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid   = 1'b1;
                    n_out_slot    = '0;
                    n_out_id      = '0;
                    n_out_ctime   = '0;
                    n_out_atime   = '0;
                    n_out_dup     = 1'b0;
                    n_out_dropped = 1'b0;
                    unique case (in_op)
                        OP_ARRIVAL: begin
                            // Settle the pending frame: publish or drop as duplicate.
                            if (r_pending_valid && in_fp_valid && !is_dup) begin
                                n_last_fp       = in_fp;
                                n_last_fp_valid = 1'b1;
                            end
                            if (is_dup) begin
                                n_duplicates = r_duplicates + CNT_W'(1);
                            end
                            n_out_dup   = is_dup;
                            n_head_idx  = head_idx_s;
                            n_head_slot = head_slot_s;
                            n_depth     = depth_s;

                            // Count repeated content times; nothing else depends on them.
                            if (r_last_time_valid && (in_ctime == r_last_ctime)) begin
                                n_time_repeats = r_time_repeats + CNT_W'(1);
                            end
                            n_last_ctime      = in_ctime;
                            n_last_time_valid = 1'b1;

                            n_pending_valid = 1'b0;
                            n_out_status    = ST_STORED;
                            if (ring_full) begin
                                n_overflows = r_overflows + CNT_W'(1);
                                if (!oldest_held) begin
                                    // Drop the oldest published frame.
                                    n_tail_idx    = r_tail_idx + IDX_W'(1);
                                    n_tail_slot   = slot_inc(r_tail_slot, r_tail_idx);
                                    n_depth       = depth_s - DEPTH_W'(1);
                                    n_out_dropped = 1'b1;
                                end
                            end
                            if (ring_full && oldest_held) begin
                                // Consumer holds the oldest: drop the arrival.
                                n_out_status = ST_DROPPED;
                            end else begin
                                mem_we          = 1'b1;
                                n_pending_valid = 1'b1;
                                n_next_id       = r_next_id + ID_W'(1);
                                n_out_id        = r_next_id;
                                slot_wide       = 32'(head_slot_s);
                                n_out_slot      = slot_wide[2:0];
                            end
                        end
                        OP_ACQUIRE: begin
                            if (r_held_valid) begin
                                n_out_status = ST_BUSY;
                            end else if (r_depth == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                // Hand out the oldest; S_READ picks up its entry from the slot memory.
                                n_held_valid = 1'b1;
                                n_held_slot  = r_tail_slot;
                                n_out_status = ST_HANDED_OUT;
                                slot_wide    = 32'(r_tail_slot);
                                n_out_slot   = slot_wide[2:0];
                                mem_re       = 1'b1;
                                n_out_valid  = 1'b0;
                                n_state      = S_READ;
                            end
                        end
                        OP_RELEASE: begin
                            if (r_held_valid && (32'(in_rel_slot) == 32'(r_held_slot))) begin
                                n_held_valid = 1'b0;
                                n_tail_idx   = r_tail_idx + IDX_W'(1);
                                n_tail_slot  = slot_inc(r_tail_slot, r_tail_idx);
                                n_depth      = r_depth - DEPTH_W'(1);
                                n_out_status = ST_RELEASED;
                            end else begin
                                n_out_status = ST_REL_IGNORED;
                            end
                        end
                        OP_CLEAR: begin
                            n_overflows    = '0;
                            n_duplicates   = '0;
                            n_time_repeats = '0;
                            n_out_status   = ST_CLEARED;
                        end
                        default: begin
                            n_out_status = ST_CLEARED;
                        end
                    endcase
                    depth_wide  = 32'(n_depth);
                    n_out_depth = depth_wide[2:0];
                end
            end
            S_READ: begin
                // Entry read has landed: complete the handed-out result.
                n_out_id    = r_rd_data[ID_W-1:0];
                n_out_ctime = r_rd_data[ID_W +: TIME_W];
                n_out_atime = r_rd_data[ID_W + TIME_W +: TIME_W];
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_head_idx        <= '0;
            r_tail_idx        <= '0;
            r_head_slot       <= '0;
            r_tail_slot       <= '0;
            r_depth           <= '0;
            r_held_valid      <= 1'b0;
            r_held_slot       <= '0;
            r_pending_valid   <= 1'b0;
            r_last_fp         <= '0;
            r_last_fp_valid   <= 1'b0;
            r_last_ctime      <= '0;
            r_last_time_valid <= 1'b0;
            r_next_id         <= ID_W'(1);
            r_overflows       <= '0;
            r_duplicates      <= '0;
            r_time_repeats    <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state           <= n_state;
            r_head_idx        <= n_head_idx;
            r_tail_idx        <= n_tail_idx;
            r_head_slot       <= n_head_slot;
            r_tail_slot       <= n_tail_slot;
            r_depth           <= n_depth;
            r_held_valid      <= n_held_valid;
            r_held_slot       <= n_held_slot;
            r_pending_valid   <= n_pending_valid;
            r_last_fp         <= n_last_fp;
            r_last_fp_valid   <= n_last_fp_valid;
            r_last_ctime      <= n_last_ctime;
            r_last_time_valid <= n_last_time_valid;
            r_next_id         <= n_next_id;
            r_overflows       <= n_overflows;
            r_duplicates      <= n_duplicates;
            r_time_repeats    <= n_time_repeats;
            r_out_valid       <= n_out_valid;
        end
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
        r_out_id      <= n_out_id;
        r_out_ctime   <= n_out_ctime;
        r_out_atime   <= n_out_atime;
        r_out_depth   <= n_out_depth;
        r_out_dup     <= n_out_dup;
        r_out_dropped <= n_out_dropped;
    end

    // Slot memory port: writes on a stored arrival, reads on a hand-out.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_time_repeats, r_duplicates, r_overflows,
                            r_out_dropped, r_out_dup, r_out_depth,
                            r_out_atime, r_out_ctime, r_out_id, r_out_slot};

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the frame ring dedup manager: random and directed request streams.
`timescale 1ns / 1ps

module tb;
    import frdm_pkg::*;

    localparam int unsigned SLOTS      = 8;
    localparam int unsigned STALL_MAX  = 4000;  // cycles with no handshake before giving up
    localparam int unsigned HOLD_OFF   = 300;   // long consumer stall that backs up the input
    localparam int unsigned DRAIN_WAIT = 10;
    localparam int unsigned RAND_REQS  = 1000;

    // One request as the block sees it.
    typedef struct packed {
        t_op         op;
        logic        fp_ok;
        logic [127:0] fp;        // word 0 in the low bits
        logic [47:0] con_time;
        logic [47:0] arr_time;
        logic [2:0]  rel_slot;
    } req_t;

    // One result as the block reports it.
    typedef struct packed {
        t_status     status;
        logic [2:0]  slot;
        logic [31:0] frame_id;
        logic [47:0] con_time;
        logic [47:0] arr_time;
        logic [2:0]  depth;
        logic        dup;
        logic        dropped;
        logic [31:0] overflows;
        logic [31:0] duplicates;
        logic [31:0] repeats;
    } rsp_t;

    // Ring bookkeeping mirrored by the bench.
    typedef struct packed {
        logic [31:0]        head;
        logic [31:0]        tail;
        logic               held;
        logic [2:0]         held_slot;
        logic               pending;
        logic [127:0]       last_fp;
        logic               last_fp_ok;
        logic [47:0]        last_ct;
        logic               last_ct_ok;
        logic [31:0]        next_id;
        logic [7:0][31:0]   ids;
        logic [7:0][47:0]   cts;
        logic [7:0][47:0]   ats;
        logic [31:0]        overflows;
        logic [31:0]        duplicates;
        logic [31:0]        repeats;
    } ring_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic [1:0]     s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [2:0]     m_axis_tuser;

    req_t        cur_req = '0;
    req_t        req_backlog[$];
    rsp_t        ring_expect_q[$];
    ring_t       gen_ring;      // advanced while the stream is built, steers releases
    ring_t       chk_ring;      // advanced on every accepted request
    int unsigned total_reqs = 0;
    int unsigned tx_count = 0;
    int unsigned rx_count = 0;
    int unsigned hold_left = 0;
    logic        pressure_done = 1'b0;
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    frame_ring_dedup_manager #(
        .RING_SLOTS(SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Pack fields from the low bit up: fingerprint valid, words 0..3, times, release slot.
    assign s_axis_tdata = {4'b0, cur_req.rel_slot, cur_req.arr_time, cur_req.con_time,
                           cur_req.fp, cur_req.fp_ok};
    assign s_axis_tuser = cur_req.op;

    function automatic ring_t ring_after_reset();
        ring_t st;
        st = '0;
        st.next_id = 32'd1;
        return st;
    endfunction

    // Work out the result of one request and advance the mirrored ring.
    function automatic rsp_t ring_advance(inout ring_t st, input req_t rq);
        rsp_t        rs;
        logic        is_dup;
        logic        keep;
        logic [2:0]  s;
        rs = '0;
        case (rq.op)
            OP_ARRIVAL: begin
                // Settle the pending frame first: drop it as a duplicate or publish it.
                if (st.pending) begin
                    is_dup = 1'b0;
                    if (rq.fp_ok) begin
                        is_dup = st.last_fp_ok && (rq.fp == st.last_fp);
                        if (!is_dup) begin
                            st.last_fp    = rq.fp;
                            st.last_fp_ok = 1'b1;
                        end
                    end
                    st.pending = 1'b0;
                    if (is_dup) begin
                        st.duplicates = st.duplicates + 32'd1;
                        rs.dup = 1'b1;
                    end else begin
                        st.head = st.head + 32'd1;
                    end
                end
                // Repeated content times are only counted.
                if (st.last_ct_ok && rq.con_time == st.last_ct)
                    st.repeats = st.repeats + 32'd1;
                st.last_ct    = rq.con_time;
                st.last_ct_ok = 1'b1;
                // Full ring: drop the oldest, unless the consumer holds it.
                keep = 1'b1;
                if ((st.head - st.tail) >= 32'(SLOTS - 1)) begin
                    st.overflows = st.overflows + 32'd1;
                    if (st.held && 3'(st.tail % SLOTS) == st.held_slot) begin
                        keep = 1'b0;
                    end else begin
                        st.tail = st.tail + 32'd1;
                        rs.dropped = 1'b1;
                    end
                end
                if (keep) begin
                    s = 3'(st.head % SLOTS);
                    st.ids[s] = st.next_id;
                    st.cts[s] = rq.con_time;
                    st.ats[s] = rq.arr_time;
                    rs.frame_id = st.next_id;
                    st.next_id = st.next_id + 32'd1;
                    st.pending = 1'b1;
                    rs.status = ST_STORED;
                    rs.slot = s;
                end else begin
                    rs.status = ST_DROPPED;
                end
            end
            OP_ACQUIRE: begin
                if (st.held) begin
                    rs.status = ST_BUSY;
                end else if (st.head == st.tail) begin
                    rs.status = ST_EMPTY;
                end else begin
                    s = 3'(st.tail % SLOTS);
                    st.held = 1'b1;
                    st.held_slot = s;
                    rs.status = ST_HANDED_OUT;
                    rs.slot = s;
                    rs.frame_id = st.ids[s];
                    rs.con_time = st.cts[s];
                    rs.arr_time = st.ats[s];
                end
            end
            OP_RELEASE: begin
                if (st.held && rq.rel_slot == st.held_slot) begin
                    st.held = 1'b0;
                    st.tail = st.tail + 32'd1;
                    rs.status = ST_RELEASED;
                end else begin
                    rs.status = ST_REL_IGNORED;
                end
            end
            default: begin
                st.overflows  = '0;
                st.duplicates = '0;
                st.repeats    = '0;
                rs.status = ST_CLEARED;
            end
        endcase
        rs.depth      = 3'(st.head - st.tail);
        rs.overflows  = st.overflows;
        rs.duplicates = st.duplicates;
        rs.repeats    = st.repeats;
        return rs;
    endfunction

    // Queue one request and advance the generator's copy of the ring.
    task automatic queue_req(input t_op op, input logic fp_ok, input logic [127:0] fp,
                             input logic [47:0] ct, input logic [47:0] at,
                             input logic [2:0] rel);
        req_t rq;
        rsp_t unused;
        rq.op = op;
        rq.fp_ok = fp_ok;
        rq.fp = fp;
        rq.con_time = ct;
        rq.arr_time = at;
        rq.rel_slot = rel;
        unused = ring_advance(gen_ring, rq);
        req_backlog.push_back(rq);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Idle percentages per phase: receiver-heavy idling, then sender-heavy, then none.
    function automatic int unsigned send_idle_pct();
        int unsigned phase;
        phase = (total_reqs == 0) ? 0 : (tx_count * 3) / total_reqs;
        return (phase == 0) ? 27 : (phase == 1) ? 77 : 0;
    endfunction

    function automatic int unsigned recv_idle_pct();
        int unsigned phase;
        phase = (total_reqs == 0) ? 0 : (rx_count * 3) / total_reqs;
        return (phase == 0) ? 77 : (phase == 1) ? 27 : 0;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Build the request stream, run reset, then wait for the ring to drain.
    initial begin
        logic [127:0] fp;
        logic [47:0]  ct;
        logic         fp_ok;
        int unsigned  r;
        int unsigned  arr_w;
        gen_ring = ring_after_reset();
        chk_ring = ring_after_reset();

        // Empty ring, nothing held, no pending frame.
        queue_req(OP_ACQUIRE, 1'b0, '0, '0, '0, 3'd0);
        queue_req(OP_RELEASE, 1'b1, '1, '1, '1, 3'd0);
        // First arrival: fingerprint inputs are ignored with nothing pending.
        queue_req(OP_ARRIVAL, 1'b1, '1, 48'd0, '1, 3'd7);
        queue_req(OP_ARRIVAL, 1'b1, '1, 48'd0, 48'd0, 3'd0);   // publish, repeated time
        queue_req(OP_ARRIVAL, 1'b1, '1, '1, rand48(), 3'd0);   // duplicate of last published
        queue_req(OP_ARRIVAL, 1'b0, '1, '1, rand48(), 3'd0);   // missing fingerprint
        queue_req(OP_ARRIVAL, 1'b1, '0, rand48(), rand48(), 3'd0);
        // Fill the ring until the oldest frames are pushed out.
        repeat (6) queue_req(OP_ARRIVAL, 1'b1, rand128(), rand48(), rand48(), 3'd0);
        queue_req(OP_ACQUIRE, 1'b0, '0, '0, '0, 3'd0);
        queue_req(OP_ACQUIRE, 1'b0, '0, '0, '0, 3'd0);          // busy
        queue_req(OP_RELEASE, 1'b0, '0, '0, '0, gen_ring.held_slot + 3'd1);
        // Full ring with the oldest held: arrivals are dropped.
        repeat (3) queue_req(OP_ARRIVAL, 1'b1, rand128(), rand48(), rand48(), 3'd0);
        queue_req(OP_RELEASE, 1'b0, '0, '0, '0, gen_ring.held_slot);
        queue_req(OP_CLEAR, 1'b1, '1, '1, '1, 3'd7);
        queue_req(OP_ACQUIRE, 1'b0, '0, '0, '0, 3'd0);
        queue_req(OP_RELEASE, 1'b0, '0, '0, '0, gen_ring.held_slot);

        // Random part: alternate producer-heavy and consumer-heavy stretches.
        for (int unsigned i = 0; i < RAND_REQS; i++) begin
            arr_w = ((i / 100) % 2 == 0) ? 55 : 25;
            r = $urandom_range(0, 99);
            if (r < arr_w) begin
                fp_ok = ($urandom_range(0, 99) < 85);
                fp = (gen_ring.last_fp_ok && $urandom_range(0, 99) < 30) ?
                     gen_ring.last_fp : rand128();
                if ($urandom_range(0, 99) < 20)
                    ct = gen_ring.last_ct;
                else if ($urandom_range(0, 99) < 30)
                    ct = 48'($urandom_range(0, 15));
                else
                    ct = rand48();
                queue_req(OP_ARRIVAL, fp_ok, fp, ct, rand48(), 3'($urandom));
            end else if (r < arr_w + 20) begin
                queue_req(OP_ACQUIRE, 1'($urandom), rand128(), rand48(), rand48(),
                          3'($urandom));
            end else if (r < 96) begin
                // Mostly release the frame that is held; sometimes a stray slot.
                queue_req(OP_RELEASE, 1'($urandom), rand128(), rand48(), rand48(),
                          (gen_ring.held && $urandom_range(0, 99) < 85) ?
                          gen_ring.held_slot : 3'($urandom));
            end else begin
                queue_req(OP_CLEAR, 1'($urandom), rand128(), rand48(), rand48(),
                          3'($urandom));
            end
        end
        total_reqs = req_backlog.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is in and every result is out.
        while (req_backlog.size() != 0 || s_axis_tvalid || ring_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("frame_ring_dedup_manager verification clean");
        else
            $display("frame_ring_dedup_manager verification failed");
        $finish;
    end

    // Request driver: hold a request until accepted, then predict its result.
    always @(posedge i_clk) begin
        logic offer;
        offer = s_axis_tvalid;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                ring_expect_q.push_back(ring_advance(chk_ring, cur_req));
                tx_count <= tx_count + 1;
                offer = 1'b0;
            end
            // Advance to the next request unless this cycle idles.
            if (!offer && req_backlog.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct()) begin
                cur_req <= req_backlog.pop_front();
                offer = 1'b1;
            end
        end
        s_axis_tvalid <= offer;
    end

    // Result monitor: compare against the oldest prediction and pace tready.
    always @(posedge i_clk) begin
        rsp_t got;
        rsp_t want;
        logic ready;
        ready = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status     = t_status'(m_axis_tuser);
                got.slot       = m_axis_tdata[2:0];
                got.frame_id   = m_axis_tdata[34:3];
                got.con_time   = m_axis_tdata[82:35];
                got.arr_time   = m_axis_tdata[130:83];
                got.depth      = m_axis_tdata[133:131];
                got.dup        = m_axis_tdata[134];
                got.dropped    = m_axis_tdata[135];
                got.overflows  = m_axis_tdata[167:136];
                got.duplicates = m_axis_tdata[199:168];
                got.repeats    = m_axis_tdata[231:200];
                rx_count <= rx_count + 1;
                if (ring_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, got);
                end else begin
                    want = ring_expect_q.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("slot", 64'(want.slot), 64'(got.slot));
                    check_field("frame_id", 64'(want.frame_id), 64'(got.frame_id));
                    check_field("frame_content_time", 64'(want.con_time),
                                64'(got.con_time));
                    check_field("frame_arrival_time", 64'(want.arr_time),
                                64'(got.arr_time));
                    check_field("queue_depth", 64'(want.depth), 64'(got.depth));
                    check_field("pending_was_duplicate", 64'(want.dup), 64'(got.dup));
                    check_field("oldest_dropped", 64'(want.dropped), 64'(got.dropped));
                    check_field("overflow_count", 64'(want.overflows), 64'(got.overflows));
                    check_field("duplicate_count", 64'(want.duplicates),
                                64'(got.duplicates));
                    check_field("timestamp_repeat_count", 64'(want.repeats),
                                64'(got.repeats));
                end
            end
            // Hold off once for a long stretch so the block backs up its input.
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (!pressure_done && total_reqs != 0 &&
                         rx_count >= (total_reqs * 3) / 4) begin
                hold_left <= HOLD_OFF;
                pressure_done <= 1'b1;
            end else begin
                ready = ($urandom_range(0, 99) >= recv_idle_pct());
            end
        end
        m_axis_tready <= ready;
    end

    // Watchdog: stop when no request or result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("frame_ring_dedup_manager verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
rtl/frdm_pkg.sv
rtl/frame_ring_dedup_manager.sv
bench/tb.sv
